[hw/rtl/buwm_pkg.sv]
// Shared types and constants for the bounded-until window monitor.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none

package buwm_pkg;

  localparam int CFG_W              = 11;
  localparam int CFG_RESET          = 17;
  localparam int WINDOW_MAX_DEFAULT = 1024;
  localparam int VERDICT_W          = 2;

  localparam logic [VERDICT_W-1:0] VERDICT_WAITING   = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_SATISFIED = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_FAILED    = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_UNDECIDED = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic store;       // write the accepted sample into the ring
    logic scan_start;  // point the scan at the oldest entry
    logic scan;        // walk the ring one entry per cycle
    logic load_out;    // move the verdict into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic filled;      // ring has held a full window since the last clear
    logic found;       // checked entry settles the verdict
    logic exhausted;   // every entry checked, nothing settled
    logic out_free;    // output register can take a word this cycle
  } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/buwm_if.sv]
// Handshake channels of the bounded-until window monitor: samples in, verdicts out.
// Depends on buwm_pkg for the verdict width.
`default_nettype none

interface buwm_sample_if;
  logic valid;
  logic ready;
  logic prop_p;
  logic prop_q;

  modport source (output valid, output prop_p, output prop_q, input ready);
  modport sink (input valid, input prop_p, input prop_q, output ready);
endinterface

interface buwm_verdict_if;
  logic                           valid;
  logic                           ready;
  logic [buwm_pkg::VERDICT_W-1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink (input valid, input verdict, output ready);
endinterface

`default_nettype wire

[hw/rtl/buwm_ctrl.sv]
// Sequencer of the bounded-until window monitor: accept, set up, scan, finish.
// Depends on buwm_pkg (state enum, command and status structs).
`default_nettype none

module buwm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire buwm_pkg::dp_status_t status,
  output buwm_pkg::dp_cmd_t         cmd
);

  buwm_pkg::ctrl_state_t state;
  buwm_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= buwm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      buwm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = buwm_pkg::ST_SETUP;
        end
      end
      buwm_pkg::ST_SETUP: begin
        state_next = status.filled ? buwm_pkg::ST_SCAN : buwm_pkg::ST_FINISH;
      end
      buwm_pkg::ST_SCAN: begin
        if (status.found || status.exhausted) begin
          state_next = buwm_pkg::ST_FINISH;
        end
      end
      buwm_pkg::ST_FINISH: begin
        if (status.out_free) begin
          state_next = buwm_pkg::ST_IDLE;
        end
      end
      default: state_next = buwm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      buwm_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.store = in_valid;
      end
      buwm_pkg::ST_SETUP: begin
        cmd.scan_start = status.filled;
      end
      buwm_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      buwm_pkg::ST_FINISH: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/buwm_dp.sv]
// Datapath of the bounded-until window monitor: window register, history ring,
// scan pointer and counter, verdict and output registers. Depends on buwm_pkg.
`default_nettype none

module buwm_dp #(
  parameter int unsigned WINDOW_MAX = buwm_pkg::WINDOW_MAX_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           prop_p,
  input  wire logic                           prop_q,
  input  wire logic                           cfg_write,
  input  wire logic [buwm_pkg::CFG_W-1:0]     cfg_data,
  input  wire buwm_pkg::dp_cmd_t              cmd,
  output buwm_pkg::dp_status_t                status,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [buwm_pkg::VERDICT_W-1:0]      out_verdict
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int MW = (LW > buwm_pkg::CFG_W) ? LW : buwm_pkg::CFG_W;
  localparam int XW = MW + 1;

  logic [buwm_pkg::CFG_W-1:0]    window_length;
  logic [AW-1:0]                 write_position;
  logic                          window_filled;
  logic [1:0]                    ring [WINDOW_MAX];   // {p, q}
  logic [1:0]                    rd_data;
  logic                          rd_valid;
  logic [AW-1:0]                 slot;
  logic [LW-1:0]                 issued;
  logic [buwm_pkg::VERDICT_W-1:0] result;

  logic [MW-1:0] len_m;
  logic [MW-1:0] eff_m;
  logic [LW-1:0] eff_len;
  logic [XW-1:0] pos_x;
  logic [AW-1:0] pos;
  logic          filled_next;
  logic [XW-1:0] wp_inc_x;
  logic [AW-1:0] first_slot;
  logic [XW-1:0] slot_inc_x;
  logic [AW-1:0] slot_next;
  logic          issue;
  logic          found;
  logic          exhausted;

  // zero means one entry, oversize saturates
  always_comb begin
    len_m = MW'(window_length);
    if (window_length == '0) begin
      eff_m = MW'(1);
    end else if (len_m > MW'(WINDOW_MAX)) begin
      eff_m = MW'(WINDOW_MAX);
    end else begin
      eff_m = len_m;
    end
    eff_len = LW'(eff_m);
  end

  always_comb begin
    pos_x       = XW'(write_position) + XW'(1);
    pos         = (pos_x >= XW'(eff_len)) ? '0 : AW'(pos_x);
    filled_next = window_filled || ((XW'(pos) + XW'(1)) == XW'(eff_len));
    wp_inc_x    = XW'(write_position) + XW'(1);
    first_slot  = (wp_inc_x >= XW'(eff_len)) ? '0 : AW'(wp_inc_x);
    slot_inc_x  = XW'(slot) + XW'(1);
    slot_next   = (slot_inc_x >= XW'(eff_len)) ? '0 : AW'(slot_inc_x);
    found       = rd_valid && (rd_data[0] || !rd_data[1]);
    exhausted   = !rd_valid && (issued == eff_len);
    issue       = cmd.scan && (issued < eff_len) && !found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= buwm_pkg::CFG_W'(buwm_pkg::CFG_RESET);
      write_position <= AW'(WINDOW_MAX - 1);
      window_filled  <= 1'b0;
    end else if (cfg_write) begin
      window_length  <= cfg_data;
      write_position <= AW'(WINDOW_MAX - 1);
      window_filled  <= 1'b0;
    end else if (cmd.store) begin
      write_position <= pos;
      window_filled  <= filled_next;
    end
  end

  // history ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      ring[pos] <= {prop_p, prop_q};
    end
    if (issue) begin
      rd_data <= ring[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      issued   <= '0;
      slot     <= '0;
    end else if (cmd.scan_start) begin
      rd_valid <= 1'b0;
      issued   <= '0;
      slot     <= first_slot;
    end else if (cmd.scan) begin
      rd_valid <= issue;
      if (issue) begin
        issued <= issued + LW'(1);
        slot   <= slot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && !filled_next) begin
      result <= buwm_pkg::VERDICT_WAITING;
    end else if (cmd.scan && found) begin
      result <= rd_data[0] ? buwm_pkg::VERDICT_SATISFIED : buwm_pkg::VERDICT_FAILED;
    end else if (cmd.scan && exhausted) begin
      result <= buwm_pkg::VERDICT_UNDECIDED;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_verdict <= result;
    end
  end

  always_comb begin
    status.filled    = window_filled;
    status.found     = found;
    status.exhausted = exhausted;
    status.out_free  = !out_valid || out_ready;
  end

  a_found_excl: assert property (@(posedge clk) disable iff (rst)
    !(found && exhausted))
    else $error("scan both settled and exhausted");

  // a length write between scans may leave the old count above the new length
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (issued <= eff_len))
    else $error("scan read past the window");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten");

endmodule

`default_nettype wire

[hw/rtl/bounded_until_window_monitor.sv]
// Top level of the bounded-until window monitor: controller plus datapath.
// Depends on buwm_pkg, buwm_if, buwm_ctrl and buwm_dp.
`default_nettype none

// Runtime monitor for "p Until q" over the last window_length time units.
//
// samples  : sink channel, one word per time unit carrying prop_p / prop_q.
// verdicts : source channel, exactly one word per accepted sample:
//            0 waiting (window not yet full), 1 satisfied, 2 failed,
//            3 undecided (every entry p=1, q=0).
// cfg_write/cfg_data : writes window_length (0 acts as 1, values above
//            WINDOW_MAX saturate). A write also empties the window. Write
//            only while the monitor is idle.
//
// Timing: the sample is written into the history ring on accept. While the
// window fills, the verdict passes through the setup and finish states into the
// output register. Once full, the ring is read oldest to newest, one entry per
// cycle through its single read port, and the scan stops at the first deciding
// entry. samples.ready is high only while idle.
//
// A stalled receiver holds the verdict in the output register; the next
// sample is still accepted and scanned, and its verdict waits for the slot.
// Reset (rst, synchronous): window_length = 17, window empty, no word out.

module bounded_until_window_monitor #(
  parameter int unsigned WINDOW_MAX = buwm_pkg::WINDOW_MAX_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  buwm_sample_if.sink                     samples,
  buwm_verdict_if.source                  verdicts,
  input  wire logic                       cfg_write,
  input  wire logic [buwm_pkg::CFG_W-1:0] cfg_data
);

  buwm_pkg::dp_cmd_t    cmd;
  buwm_pkg::dp_status_t status;
  logic                 in_ready;
  logic                 out_valid;
  logic [buwm_pkg::VERDICT_W-1:0] out_verdict;

  buwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  buwm_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .prop_p      (samples.prop_p),
    .prop_q      (samples.prop_q),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (verdicts.ready),
    .out_verdict (out_verdict)
  );

  assign samples.ready    = in_ready;
  assign verdicts.valid   = out_valid;
  assign verdicts.verdict = out_verdict;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for bounded_until_window_monitor: random and directed p/q samples,
// a predictor of the until verdict and an in-order verdict scoreboard.
// Depends on buwm_pkg, buwm_if and the monitor RTL only.

module tb_top;

  // The limit leaves a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT  = 400000;
  // Receiver back-pressure burst: starts after this many checked words.
  localparam int HOLD_AT_WORD = 250;
  localparam int LONG_HOLD    = 300;
  localparam int RING_DEPTH   = buwm_pkg::WINDOW_MAX_DEFAULT;

  typedef struct packed {
    logic p;
    logic q;
  } unit_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [buwm_pkg::CFG_W-1:0] cfg_data;

  buwm_sample_if  samples ();
  buwm_verdict_if verdicts ();

  bounded_until_window_monitor u_dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .verdicts (verdicts),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  // Predictor state: shadow of window_length plus our own copy of the history ring.
  logic [buwm_pkg::CFG_W-1:0] win_len_shadow;
  bit                         p_ring [RING_DEPTH];
  bit                         q_ring [RING_DEPTH];
  int unsigned                newest_slot;
  bit                         ring_full;

  logic [buwm_pkg::VERDICT_W-1:0] verdicts_due [$];   // expected verdicts, oldest first
  unit_t                          pending_units [$];  // samples not yet offered

  int mismatches;
  int words_checked;
  int cycle_count;
  int send_gap;
  int hold_left;
  bit calm;          // when set, neither side inserts gaps
  bit sample_fire;   // sample word accepted at the last rising edge
  bit verdict_fire;  // verdict word accepted at the last rising edge

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // Emptying the window: the next sample lands in slot zero.
  function automatic void clear_ring();
    newest_slot = RING_DEPTH - 1;
    ring_full   = 1'b0;
  endfunction

  // Store one time unit and return the verdict it produces. Zero length acts as one,
  // lengths above the ring depth saturate. The scan runs oldest to newest and wraps.
  function automatic logic [buwm_pkg::VERDICT_W-1:0] until_verdict(logic p, logic q);
    int unsigned                    span;
    int unsigned                    slot;
    logic [buwm_pkg::VERDICT_W-1:0] v;
    span = (win_len_shadow == 0) ? 1 :
           (win_len_shadow > RING_DEPTH) ? RING_DEPTH : win_len_shadow;
    newest_slot = (newest_slot + 1 >= span) ? 0 : newest_slot + 1;
    p_ring[newest_slot] = p;
    q_ring[newest_slot] = q;
    if (newest_slot == span - 1) ring_full = 1'b1;
    if (!ring_full) return buwm_pkg::VERDICT_WAITING;
    v    = buwm_pkg::VERDICT_UNDECIDED;
    slot = (newest_slot + 1 >= span) ? 0 : newest_slot + 1;
    for (int k = 0; k < span && v == buwm_pkg::VERDICT_UNDECIDED; k++) begin
      if (q_ring[slot]) v = buwm_pkg::VERDICT_SATISFIED;
      else if (!p_ring[slot]) v = buwm_pkg::VERDICT_FAILED;
      slot = (slot + 1 >= span) ? 0 : slot + 1;
    end
    return v;
  endfunction

  // Rising edge: register writes, verdict check, then prediction for an accepted sample.
  // The check runs first so a stray verdict cannot consume the expectation just pushed.
  always @(posedge clk) begin
    if (rst) begin
      win_len_shadow = buwm_pkg::CFG_W'(buwm_pkg::CFG_RESET);
      clear_ring();
      sample_fire  <= 1'b0;
      verdict_fire <= 1'b0;
    end else begin
      cycle_count++;
      if (cfg_write) begin
        win_len_shadow = cfg_data;
        clear_ring();
      end
      if (verdicts.valid && verdicts.ready) begin
        words_checked++;
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with none expected", verdicts.verdict));
        end else if (verdicts.verdict !== verdicts_due[0]) begin
          report_mismatch($sformatf("word %0d: verdict %0d, expected %0d",
                                    words_checked, verdicts.verdict, verdicts_due[0]));
          void'(verdicts_due.pop_front());
        end else begin
          void'(verdicts_due.pop_front());
        end
      end
      if (samples.valid && samples.ready)
        verdicts_due.push_back(until_verdict(samples.prop_p, samples.prop_q));
      sample_fire  <= samples.valid && samples.ready;
      verdict_fire <= verdicts.valid && verdicts.ready;
    end
  end

  // Sample driver: offers queued words at the falling edge, with a random gap drawn
  // per word. valid gets exactly one update per edge.
  always @(negedge clk) begin : drive_samples
    logic  offer;
    unit_t unit;
    if (rst) begin
      samples.valid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = samples.valid && !sample_fire;
      if (!offer && pending_units.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else begin
          unit = pending_units.pop_front();
          samples.prop_p <= unit.p;
          samples.prop_q <= unit.q;
          offer    = 1'b1;
          send_gap = calm ? 0 : $urandom_range(0, 3);
        end
      end
      samples.valid <= offer;
    end
  end

  // Verdict receiver: after each accepted word it drops ready for a random gap. Once,
  // it holds off for a long burst so the output register fills and the block stops
  // taking samples while the driver keeps offering.
  always @(negedge clk) begin : drive_verdict_ready
    if (rst) begin
      verdicts.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (verdict_fire) begin
        hold_left = calm ? 0 : $urandom_range(0, 3);
        if (words_checked == HOLD_AT_WORD) hold_left = LONG_HOLD;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      verdicts.ready <= (hold_left == 0);
    end
  end

  initial begin
    wait (cycle_count > CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  task automatic push_unit(logic p, logic q);
    unit_t unit;
    unit.p = p;
    unit.q = q;
    pending_units.push_back(unit);
  endtask

  // Random time units for a window of the given span. Most stretches are mostly
  // p=1/q=0 with rare deciding events (so all three verdicts show up and full scans
  // happen); about a quarter of the stretches are plain noise.
  task automatic queue_units(int count, int span);
    int r;
    bit noisy;
    noisy = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) noisy = ($urandom_range(0, 3) == 0);
      if (noisy) begin
        push_unit($urandom_range(0, 1), $urandom_range(0, 1));
      end else begin
        r = $urandom_range(0, 3 * span + 2);
        if (r == 0) push_unit(1'b0, 1'b0);
        else if (r == 1) push_unit($urandom_range(0, 1), 1'b1);
        else push_unit(1'b1, 1'b0);
      end
    end
  endtask

  // Wait until every queued word went in and every verdict came out, then let the
  // controller return to idle.
  task automatic settle();
    do @(posedge clk);
    while (pending_units.size() != 0 || samples.valid || verdicts_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Register write while idle; also picks whether the next phase runs gap-free.
  task automatic write_window(logic [buwm_pkg::CFG_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    calm = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    int span;
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_data       = '0;
    samples.valid  = 1'b0;
    samples.prop_p = 1'b0;
    samples.prop_q = 1'b0;
    verdicts.ready = 1'b0;
    calm           = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset length 17: sixteen waiting words, then q arrives as the window fills.
    for (int i = 0; i < 16; i++) push_unit(1'b1, 1'b0);
    push_unit(1'b1, 1'b1);
    push_unit(1'b0, 1'b1);
    push_unit(1'b0, 1'b0);
    push_unit(1'b1, 1'b0);

    // Zero length acts as a one-unit window: each sample decides on its own.
    write_window('0);
    push_unit(1'b0, 1'b0);
    push_unit(1'b1, 1'b0);
    push_unit(1'b0, 1'b1);
    push_unit(1'b1, 1'b1);
    queue_units(30, 1);

    write_window(buwm_pkg::CFG_W'(1));
    queue_units(30, 1);
    write_window(buwm_pkg::CFG_W'(2));
    queue_units(40, 2);
    write_window(buwm_pkg::CFG_W'(3));
    queue_units(60, 3);
    write_window(buwm_pkg::CFG_W'(buwm_pkg::CFG_RESET));
    queue_units(60, buwm_pkg::CFG_RESET);
    for (int n = 0; n < 4; n++) begin
      span = $urandom_range(4, 40);
      write_window(buwm_pkg::CFG_W'(span));
      queue_units(60, span);
    end

    // All-ones register saturates to the ring depth: a short run stays waiting.
    write_window('1);
    queue_units(50, RING_DEPTH);

    write_window(buwm_pkg::CFG_W'(5));
    queue_units(40, 5);

    settle();
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[bounded_until_window_monitor.f]
hw/rtl/buwm_pkg.sv
hw/rtl/buwm_if.sv
hw/rtl/buwm_ctrl.sv
hw/rtl/buwm_dp.sv
hw/rtl/bounded_until_window_monitor.sv
tb/tb_top.sv
